// File: rtl/segment_intersection_2d_macros.svh
// ----------------------------------------------------------------------------
// Segment intersection assertion macros
// Shared concurrent assertion wrappers for the segment intersection block.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_2D_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_MACROS_SVH

`ifndef ASSERT_OFF
`define SIA_ASSERT(LBL, CLK, RSTN, PROP) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
        else $error("sia assertion failed");
`define SIA_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("sia implication failed");
`else
`define SIA_ASSERT(LBL, CLK, RSTN, PROP)
`define SIA_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS)
`endif

`endif

// File: rtl/sia_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants, codes and types.
// ----------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int TOL_FRAC       = 16;
    localparam int PTOL_W         = 32;
    localparam int FTOL_W         = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 32;
    localparam int OUT_W          = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PTOL = 1'b0,
        CFG_FTOL = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REL_NONE    = 2'd0,
        REL_POINT   = 2'd1,
        REL_OVERLAP = 2'd2
    } rel_t;

    typedef struct packed {
        logic vld;
        rel_t rel;
    } sia_ctl_t;

endpackage

`default_nettype wire

// File: rtl/sia_front.sv
// ----------------------------------------------------------------------------
// Segment intersection front end
// Cross products, branch selection, tolerance tests and clamping (6 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module sia_front import sia_pkg::*; #(
    parameter int CB = COORD_BITS_DEF,
    parameter int MW = 2 * (CB + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_vld,
    input  wire logic [8*CB-1:0]      in_pts,
    input  wire logic [PTOL_W-1:0]    ptol,
    input  wire logic [FTOL_W-1:0]    ftol,
    output sia_ctl_t                  ctl,
    output logic signed [CB-1:0]      base_x,
    output logic signed [CB-1:0]      base_y,
    output logic signed [CB:0]        delta_x,
    output logic signed [CB:0]        delta_y,
    output logic [MW-1:0]             num0,
    output logic [MW-1:0]             num1,
    output logic [MW-1:0]             den
);

    localparam int DW = CB + 1;
    localparam int PW = MW + 1;
    localparam int CW = PW + 2;
    localparam int TW = (MW > PTOL_W) ? MW : PTOL_W;

    // stage 1: differences
    logic signed [CB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic                 v1_reg;
    logic signed [DW-1:0] dpx1_reg, dpy1_reg, dqx1_reg, dqy1_reg;
    logic signed [DW-1:0] wx1_reg, wy1_reg, ux1_reg, uy1_reg;
    logic signed [CB-1:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;

    assign ax1 = signed'(in_pts[0*CB +: CB]);
    assign ay1 = signed'(in_pts[1*CB +: CB]);
    assign ax2 = signed'(in_pts[2*CB +: CB]);
    assign ay2 = signed'(in_pts[3*CB +: CB]);
    assign bx1 = signed'(in_pts[4*CB +: CB]);
    assign by1 = signed'(in_pts[5*CB +: CB]);
    assign bx2 = signed'(in_pts[6*CB +: CB]);
    assign by2 = signed'(in_pts[7*CB +: CB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpx1_reg <= DW'(ax2) - DW'(ax1);
            dpy1_reg <= DW'(ay2) - DW'(ay1);
            dqx1_reg <= DW'(bx2) - DW'(bx1);
            dqy1_reg <= DW'(by2) - DW'(by1);
            wx1_reg  <= DW'(ax1) - DW'(bx1);
            wy1_reg  <= DW'(ay1) - DW'(by1);
            ux1_reg  <= DW'(ax2) - DW'(bx1);
            uy1_reg  <= DW'(ay2) - DW'(by1);
            ax1_reg  <= ax1;
            ay1_reg  <= ay1;
            bx1_reg  <= bx1;
            by1_reg  <= by1;
        end
    end

    // stage 2: products
    logic                 v2_reg;
    logic signed [MW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [DW-1:0] dpx2_reg, dpy2_reg, dqx2_reg, dqy2_reg;
    logic signed [DW-1:0] wx2_reg, wy2_reg, ux2_reg, uy2_reg;
    logic signed [CB-1:0] ax2_reg, ay2_reg, bx2_reg, by2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= MW'(dpx1_reg) * MW'(dqy1_reg);
            p2_reg   <= MW'(dpy1_reg) * MW'(dqx1_reg);
            p3_reg   <= MW'(dpx1_reg) * MW'(wy1_reg);
            p4_reg   <= MW'(dpy1_reg) * MW'(wx1_reg);
            p5_reg   <= MW'(dqx1_reg) * MW'(wy1_reg);
            p6_reg   <= MW'(dqy1_reg) * MW'(wx1_reg);
            dpx2_reg <= dpx1_reg;
            dpy2_reg <= dpy1_reg;
            dqx2_reg <= dqx1_reg;
            dqy2_reg <= dqy1_reg;
            wx2_reg  <= wx1_reg;
            wy2_reg  <= wy1_reg;
            ux2_reg  <= ux1_reg;
            uy2_reg  <= uy1_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            bx2_reg  <= bx1_reg;
            by2_reg  <= by1_reg;
        end
    end

    // stage 3: cross products
    logic                 v3_reg;
    logic signed [PW-1:0] denom_reg, cp_reg, cq_reg;
    logic signed [DW-1:0] dpx3_reg, dpy3_reg, dqx3_reg, dqy3_reg;
    logic signed [DW-1:0] wx3_reg, wy3_reg, ux3_reg, uy3_reg;
    logic signed [CB-1:0] ax3_reg, ay3_reg, bx3_reg, by3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            denom_reg <= PW'(p1_reg) - PW'(p2_reg);
            cp_reg    <= PW'(p3_reg) - PW'(p4_reg);
            cq_reg    <= PW'(p5_reg) - PW'(p6_reg);
            dpx3_reg  <= dpx2_reg;
            dpy3_reg  <= dpy2_reg;
            dqx3_reg  <= dqx2_reg;
            dqy3_reg  <= dqy2_reg;
            wx3_reg   <= wx2_reg;
            wy3_reg   <= wy2_reg;
            ux3_reg   <= ux2_reg;
            uy3_reg   <= uy2_reg;
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            bx3_reg   <= bx2_reg;
            by3_reg   <= by2_reg;
        end
    end

    // stage 4: branch selection
    logic [PW-1:0]        mden, mcp, mcq;
    logic [DW-1:0]        mdqx, mdqy;
    logic                 par, apart, xsel;
    logic signed [DW-1:0] dsel, n0s, n1s;
    logic signed [DW:0]   nn0, nn1;
    logic signed [CW-1:0] na_next, nb_next;
    logic [MW-1:0]        den_next;

    always_comb
    begin
        mden  = denom_reg[PW-1] ? PW'(-denom_reg) : PW'(denom_reg);
        mcp   = cp_reg[PW-1] ? PW'(-cp_reg) : PW'(cp_reg);
        mcq   = cq_reg[PW-1] ? PW'(-cq_reg) : PW'(cq_reg);
        par   = TW'(mden[MW-1:0]) <= TW'(ptol);
        apart = (TW'(mcp[MW-1:0]) > TW'(ptol)) || (TW'(mcq[MW-1:0]) > TW'(ptol));
        mdqx  = dqx3_reg[DW-1] ? DW'(-dqx3_reg) : DW'(dqx3_reg);
        mdqy  = dqy3_reg[DW-1] ? DW'(-dqy3_reg) : DW'(dqy3_reg);
        xsel  = mdqx > mdqy;
        dsel  = xsel ? dqx3_reg : dqy3_reg;
        n0s   = xsel ? wx3_reg : wy3_reg;
        n1s   = xsel ? ux3_reg : uy3_reg;
        nn0   = dsel[DW-1] ? -(DW+1)'(n0s) : (DW+1)'(n0s);
        nn1   = dsel[DW-1] ? -(DW+1)'(n1s) : (DW+1)'(n1s);
        if (par)
        begin
            den_next = MW'(xsel ? mdqx : mdqy);
            na_next  = (nn0 > nn1) ? CW'(nn1) : CW'(nn0);
            nb_next  = (nn0 > nn1) ? CW'(nn0) : CW'(nn1);
        end
        else
        begin
            den_next = mden[MW-1:0];
            na_next  = denom_reg[PW-1] ? -CW'(cq_reg) : CW'(cq_reg);
            nb_next  = denom_reg[PW-1] ? -CW'(cp_reg) : CW'(cp_reg);
        end
    end

    logic                 v4_reg, par4_reg, apart4_reg, degen4_reg;
    logic [MW-1:0]        den4_reg;
    logic signed [CW-1:0] na4_reg, nb4_reg;
    logic signed [DW-1:0] dx4_reg, dy4_reg;
    logic signed [CB-1:0] bsx4_reg, bsy4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par4_reg   <= par;
            apart4_reg <= apart;
            degen4_reg <= (dsel == '0);
            den4_reg   <= den_next;
            na4_reg    <= na_next;
            nb4_reg    <= nb_next;
            dx4_reg    <= par ? dqx3_reg : dpx3_reg;
            dy4_reg    <= par ? dqy3_reg : dpy3_reg;
            bsx4_reg   <= par ? bx3_reg : ax3_reg;
            bsy4_reg   <= par ? by3_reg : ay3_reg;
        end
    end

    // stage 5: fraction tolerance scaled to the denominator
    logic                 v5_reg, par5_reg, apart5_reg, degen5_reg;
    logic [MW-1:0]        den5_reg, tol5_reg;
    logic signed [CW-1:0] na5_reg, nb5_reg;
    logic signed [DW-1:0] dx5_reg, dy5_reg;
    logic signed [CB-1:0] bsx5_reg, bsy5_reg;
    logic [FTOL_W+MW-1:0] tol_prod;

    assign tol_prod = (FTOL_W+MW)'(ftol) * (FTOL_W+MW)'(den4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tol5_reg   <= tol_prod[TOL_FRAC +: MW];
            par5_reg   <= par4_reg;
            apart5_reg <= apart4_reg;
            degen5_reg <= degen4_reg;
            den5_reg   <= den4_reg;
            na5_reg    <= na4_reg;
            nb5_reg    <= nb4_reg;
            dx5_reg    <= dx4_reg;
            dy5_reg    <= dy4_reg;
            bsx5_reg   <= bsx4_reg;
            bsy5_reg   <= bsy4_reg;
        end
    end

    // stage 6: range tests, clamp, classification
    logic signed [CW-1:0] dsx, tsx;
    logic                 c1, c2, c3, c4, reject;
    logic [MW-1:0]        ca, cb;
    rel_t                 rel;
    logic                 v6_reg;
    rel_t                 rel6_reg;

    always_comb
    begin
        dsx    = CW'({1'b0, den5_reg});
        tsx    = CW'({1'b0, tol5_reg});
        c1     = (na5_reg - dsx) > tsx;
        c2     = (-nb5_reg) > tsx;
        c3     = (-na5_reg) > tsx;
        c4     = (nb5_reg - dsx) > tsx;
        reject = c1 || c2 || (!par5_reg && (c3 || c4));
        if (na5_reg[CW-1])
            ca = '0;
        else if (na5_reg > dsx)
            ca = den5_reg;
        else
            ca = na5_reg[MW-1:0];
        if (nb5_reg[CW-1])
            cb = '0;
        else if (nb5_reg > dsx)
            cb = den5_reg;
        else
            cb = nb5_reg[MW-1:0];
        if (par5_reg)
        begin
            if (apart5_reg || degen5_reg || reject)
                rel = REL_NONE;
            else if (ca == cb)
                rel = REL_POINT;
            else
                rel = REL_OVERLAP;
        end
        else
            rel = reject ? REL_NONE : REL_POINT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel6_reg <= rel;
            base_x   <= bsx5_reg;
            base_y   <= bsy5_reg;
            delta_x  <= dx5_reg;
            delta_y  <= dy5_reg;
            num0     <= ca;
            num1     <= cb;
            den      <= den5_reg;
        end
    end

    assign ctl = '{vld: v6_reg, rel: rel6_reg};

endmodule

`default_nettype wire

// File: rtl/sia_div.sv
// ----------------------------------------------------------------------------
// Segment intersection divider
// Product a*n then a restoring divide of (a*n) << FB by d, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_div import sia_pkg::*; #(
    parameter int CB = COORD_BITS_DEF,
    parameter int FB = FRAC_BITS_DEF,
    parameter int MW = 2 * (CB + 1),
    parameter int SW = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic [CB-1:0]      a,
    input  wire logic [MW-1:0]      n,
    input  wire logic [MW-1:0]      d,
    input  wire logic [SW-1:0]      side_in,
    output logic                    out_vld,
    output logic [CB+FB-1:0]        q,
    output logic [MW-1:0]           rem,
    output logic [MW-1:0]           d_out,
    output logic [SW-1:0]           side_out
);

    localparam int QB = CB + FB;
    localparam int PB = CB + MW;

    logic          pv_reg;
    logic [PB-1:0] p_reg;
    logic [MW-1:0] pd_reg;
    logic [SW-1:0] ps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= PB'(a) * PB'(n);
            pd_reg <= d;
            ps_reg <= side_in;
        end
    end

    logic          vld_reg  [QB];
    logic [MW-1:0] rem_reg  [QB];
    logic [QB-1:0] q_reg    [QB];
    logic [QB-1:0] low_reg  [QB];
    logic [MW-1:0] d_reg    [QB];
    logic [SW-1:0] side_reg [QB];

    logic          vin   [QB];
    logic [MW-1:0] rin   [QB];
    logic [QB-1:0] qin   [QB];
    logic [QB-1:0] lin   [QB];
    logic [MW-1:0] din   [QB];
    logic [SW-1:0] sin   [QB];
    logic [MW:0]   rsh   [QB];
    logic          ge    [QB];
    logic [MW-1:0] rnext [QB];

    always_comb
    begin
        for (int i = 0; i < QB; i++)
        begin
            if (i == 0)
            begin
                vin[i] = pv_reg;
                rin[i] = p_reg[PB-1:CB];
                qin[i] = '0;
                lin[i] = {p_reg[CB-1:0], {FB{1'b0}}};
                din[i] = pd_reg;
                sin[i] = ps_reg;
            end
            else
            begin
                vin[i] = vld_reg[i-1];
                rin[i] = rem_reg[i-1];
                qin[i] = q_reg[i-1];
                lin[i] = low_reg[i-1];
                din[i] = d_reg[i-1];
                sin[i] = side_reg[i-1];
            end
            rsh[i]   = {rin[i], lin[i][QB-1]};
            ge[i]    = rsh[i] >= {1'b0, din[i]};
            rnext[i] = ge[i] ? MW'(rsh[i] - {1'b0, din[i]}) : rsh[i][MW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QB; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < QB; i++)
                vld_reg[i] <= vin[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QB; i++)
            begin
                rem_reg[i]  <= rnext[i];
                q_reg[i]    <= {qin[i][QB-2:0], ge[i]};
                low_reg[i]  <= {lin[i][QB-2:0], 1'b0};
                d_reg[i]    <= din[i];
                side_reg[i] <= sin[i];
            end
        end
    end

    assign out_vld  = vld_reg[QB-1];
    assign q        = q_reg[QB-1];
    assign rem      = rem_reg[QB-1];
    assign d_out    = d_reg[QB-1];
    assign side_out = side_reg[QB-1];

endmodule

`default_nettype wire

// File: rtl/segment_intersection_2d.sv
// ----------------------------------------------------------------------------
// Segment intersection 2-D
// Classifies two integer segments and returns crossing point or overlap ends
// in fixed point, rounded to nearest.
//
//   channel  dir  signals                       payload
//   s_       in   s_tvalid s_tready s_tdata     8 coords, COORD_BITS each
//   m_       out  m_tvalid m_tready m_tdata     hit_x hit_y hit_end_x hit_end_y
//                 m_tuser                       relation
//   cfg_     in   cfg_we cfg_index cfg_data     tolerance registers
//
// One request per cycle while m_tready does not stall the pipeline. The
// divider pipeline resolves one quotient bit per stage.
// Reset clears valid bits and tolerances to zero.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_2d import sia_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [8*COORD_BITS-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // hit_x, hit_y, hit_end_x, hit_end_y
    output logic [4*OUT_W-1:0]           m_tdata,
    // relation
    output logic [1:0]                   m_tuser,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int FB = FRAC_BITS;
    localparam int MW = 2 * (CB + 1);
    localparam int QB = CB + FB;
    localparam int VW = (CB + FB + 2 > OUT_W + 1) ? CB + FB + 2 : OUT_W + 1;

    logic [PTOL_W-1:0] ptol_reg;
    logic [FTOL_W-1:0] ftol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptol_reg <= '0;
            ftol_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PTOL: ptol_reg <= cfg_data[PTOL_W-1:0];
                CFG_FTOL: ftol_reg <= cfg_data[FTOL_W-1:0];
                default:  ptol_reg <= ptol_reg;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    sia_ctl_t             fctl;
    logic signed [CB-1:0] base_x, base_y;
    logic signed [CB:0]   delta_x, delta_y;
    logic [MW-1:0]        num0, num1, den;

    sia_front #(
        .CB (CB),
        .MW (MW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_tvalid),
        .in_pts  (s_tdata),
        .ptol    (ptol_reg),
        .ftol    (ftol_reg),
        .ctl     (fctl),
        .base_x  (base_x),
        .base_y  (base_y),
        .delta_x (delta_x),
        .delta_y (delta_y),
        .num0    (num0),
        .num1    (num1),
        .den     (den)
    );

    logic [CB-1:0] mag_x, mag_y;

    assign mag_x = delta_x[CB] ? CB'(-delta_x) : CB'(delta_x);
    assign mag_y = delta_y[CB] ? CB'(-delta_y) : CB'(delta_y);

    logic          dv;
    logic [QB-1:0] q0, q1, q2, q3;
    logic [MW-1:0] r0, r1, r2, r3;
    logic [MW-1:0] d0, d1, d2, d3;
    logic [CB+2:0] s0;
    logic [CB:0]   s1, s2, s3;

    sia_div #(.CB(CB), .FB(FB), .MW(MW), .SW(CB + 3)) u_div_x0 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_vld (fctl.vld),
        .a (mag_x), .n (num0), .d (den),
        .side_in ({fctl.rel, delta_x[CB], base_x}),
        .out_vld (dv), .q (q0), .rem (r0), .d_out (d0), .side_out (s0)
    );

    sia_div #(.CB(CB), .FB(FB), .MW(MW), .SW(CB + 1)) u_div_y0 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_vld (fctl.vld),
        .a (mag_y), .n (num0), .d (den),
        .side_in ({delta_y[CB], base_y}),
        .out_vld (), .q (q1), .rem (r1), .d_out (d1), .side_out (s1)
    );

    sia_div #(.CB(CB), .FB(FB), .MW(MW), .SW(CB + 1)) u_div_x1 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_vld (fctl.vld),
        .a (mag_x), .n (num1), .d (den),
        .side_in ({delta_x[CB], base_x}),
        .out_vld (), .q (q2), .rem (r2), .d_out (d2), .side_out (s2)
    );

    sia_div #(.CB(CB), .FB(FB), .MW(MW), .SW(CB + 1)) u_div_y1 (
        .clk (clk), .rst_n (rst_n), .en (en), .in_vld (fctl.vld),
        .a (mag_y), .n (num1), .d (den),
        .side_in ({delta_y[CB], base_y}),
        .out_vld (), .q (q3), .rem (r3), .d_out (d3), .side_out (s3)
    );

    function automatic logic [OUT_W-1:0] finish(
        input logic [QB-1:0] qv,
        input logic [MW-1:0] rv,
        input logic [MW-1:0] dvv,
        input logic          neg,
        input logic [CB-1:0] base
    );
        logic [QB:0]          m;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] vmax;
        logic signed [VW-1:0] vmin;
        m    = {1'b0, qv} + (QB+1)'({1'b0, rv} >= ({1'b0, dvv} - {1'b0, rv}));
        v    = VW'(signed'(base)) <<< FB;
        v    = neg ? v - VW'(m) : v + VW'(m);
        vmax = signed'({{(VW-OUT_W){1'b0}}, {1'b0, {(OUT_W-1){1'b1}}}});
        vmin = signed'({{(VW-OUT_W){1'b1}}, {1'b1, {(OUT_W-1){1'b0}}}});
        if (v > vmax)
            v = vmax;
        else if (v < vmin)
            v = vmin;
        return v[OUT_W-1:0];
    endfunction

    rel_t             rel_fin;
    logic [OUT_W-1:0] hx, hy, hex, hey;

    always_comb
    begin
        rel_fin = rel_t'(s0[CB+2:CB+1]);
        hx      = finish(q0, r0, d0, s0[CB], s0[CB-1:0]);
        hy      = finish(q1, r1, d1, s1[CB], s1[CB-1:0]);
        hex     = finish(q2, r2, d2, s2[CB], s2[CB-1:0]);
        hey     = finish(q3, r3, d3, s3[CB], s3[CB-1:0]);
        if (rel_fin == REL_NONE)
        begin
            hx = '0;
            hy = '0;
        end
        if (rel_fin != REL_OVERLAP)
        begin
            hex = '0;
            hey = '0;
        end
    end

    logic [1:0]         rel_reg;
    logic [4*OUT_W-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= dv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rel_reg  <= rel_fin;
            data_reg <= {hey, hex, hy, hx};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = rel_reg;

`include "segment_intersection_2d_macros.svh"

    `SIA_ASSERT_IMP(a_none_zero, clk, rst_n, m_tvalid && (m_tuser == REL_NONE), m_tdata == '0)
    `SIA_ASSERT_IMP(a_end_zero, clk, rst_n, m_tvalid && (m_tuser != REL_OVERLAP), m_tdata[4*OUT_W-1:2*OUT_W] == '0)
    `SIA_ASSERT_IMP(a_ready_free, clk, rst_n, !m_tvalid, s_tready)
    `SIA_ASSERT_IMP(a_ready_stall, clk, rst_n, m_tvalid && !m_tready, !s_tready)

endmodule

`default_nettype wire
